/* rtl/gkg_pkg.sv */
// Package: item types, divider request type and fixed constants of the kernel generator.
package gkg_pkg;

  // Request item
  typedef struct packed {
    logic [2:0]  kernel_size;
    logic [11:0] sigma;
    logic        mode;
  } in_item_t;

  // Result item: one coefficient
  typedef struct packed {
    logic [2:0]  row;
    logic [2:0]  column;
    logic [23:0] coefficient;
    logic        last;
  } out_item_t;

  localparam int unsigned DVD_W  = 64;  // divider dividend / quotient width
  localparam int unsigned DVS_W  = 32;  // divider divisor width
  localparam int unsigned NBIT_W = 7;   // dividend bit count, up to 64

  // Divider request
  typedef struct packed {
    logic              start;
    logic [DVD_W-1:0]  dividend;
    logic [DVS_W-1:0]  divisor;
    logic [NBIT_W-1:0] nbits;
  } div_req_t;

  localparam logic [31:0] INV_E_Q32    = 32'd1580030169;
  localparam logic [3:0]  SERIES_TERMS = 4'd12;
  localparam logic [31:0] MAX_EXP_INT  = 32'd24;
  localparam logic [23:0] COEF_MAX     = 24'hFFFFFF;
  localparam int unsigned IDX_W        = 6;  // linear entry index, up to 48
  localparam logic [NBIT_W-1:0] ARG_NBITS  = 7'd53;  // (d2 << 47) + rounding
  localparam logic [NBIT_W-1:0] TERM_NBITS = 7'd33;  // series term, up to 2^32

endpackage

/* rtl/gkg_ram.sv */
// Generic single-write, single-read RAM with registered read data.
module gkg_ram #(
  parameter int unsigned WIDTH = 8,
  parameter int unsigned DEPTH = 16,
  parameter int unsigned AW    = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
  input  logic             clk_i,
  input  logic             we_i,
  input  logic [AW-1:0]    waddr_i,
  input  logic [WIDTH-1:0] wdata_i,
  input  logic [AW-1:0]    raddr_i,
  output logic [WIDTH-1:0] rdata_o
);

  logic [WIDTH-1:0] mem_q [DEPTH];

  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem_q[waddr_i] <= wdata_i;
    end
    rdata_o <= mem_q[raddr_i];
  end

endmodule

/* rtl/gkg_div.sv */
// Shared restoring divider, one quotient bit per cycle.
module gkg_div import gkg_pkg::*; (
  input  logic             clk_i,
  input  logic             rst_ni,
  input  div_req_t         req_i,
  output logic             done_o,
  output logic [DVD_W-1:0] quotient_o
);

  logic              busy_q;
  logic              done_q;
  logic [5:0]        bit_q;
  logic [DVS_W-1:0]  rem_q;
  logic [DVS_W-1:0]  dvs_q;
  logic [DVD_W-1:0]  dvd_q;
  logic [DVD_W-1:0]  quo_q;
  logic [DVS_W:0]    rem_sh;
  logic              fits;

  // Shift in the next dividend bit and trial subtract
  assign rem_sh = {rem_q, dvd_q[bit_q]};
  assign fits   = (rem_sh >= {1'b0, dvs_q});

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      busy_q <= 1'b0;
      done_q <= 1'b0;
      bit_q  <= '0;
    end else begin
      done_q <= !req_i.start && busy_q && (bit_q == 6'd0);
      if (req_i.start) begin
        busy_q <= 1'b1;
        bit_q  <= 6'(req_i.nbits - NBIT_W'(1));
      end else if (busy_q) begin
        if (bit_q == 6'd0) begin
          busy_q <= 1'b0;
        end else begin
          bit_q <= bit_q - 6'd1;
        end
      end
    end
  end

  // Datapath
  always_ff @(posedge clk_i) begin
    if (req_i.start) begin
      rem_q <= '0;
      quo_q <= '0;
      dvd_q <= req_i.dividend;
      dvs_q <= req_i.divisor;
    end else if (busy_q) begin
      if (fits) begin
        rem_q <= DVS_W'(rem_sh - {1'b0, dvs_q});
      end else begin
        rem_q <= rem_sh[DVS_W-1:0];
      end
      quo_q[bit_q] <= fits;
    end
  end

  assign done_o     = done_q;
  assign quotient_o = quo_q;

endmodule

/* rtl/gaussian_kernel_generator_unit.sv */
// Top level: Gaussian kernel coefficient generator with a shared divider and multiplier.
//
//   channel | direction | payload    | handshake
//   in      | input     | in_item_i  | in_valid_i / in_stall_o
//   out     | output    | out_item_o | out_valid_o / out_stall_i
//
// Each coefficient is computed in turn on one divider and one multiplier:
// exponent argument (one divide), 12 series terms (each a multiply plus a
// divide), up to 24 e^-1 multiplies, and a store; then each weight is read
// back and normalized by a divide, unless the divisor is zero.
// Reset clears the sequencer and output valid; the weight store needs no clearing.
// A stalled output holds the sequencer at the emit step; input is stalled while busy.
module gaussian_kernel_generator_unit import gkg_pkg::*; #(
  parameter int unsigned MAX_SIZE  = 7,
  parameter int unsigned FRAC_BITS = 16
) (
  input  logic      clk_i,
  input  logic      rst_ni,
  input  logic      in_valid_i,
  output logic      in_stall_o,
  input  in_item_t  in_item_i,
  output logic      out_valid_o,
  input  logic      out_stall_i,
  output out_item_t out_item_o
);

  localparam int unsigned DEPTH = MAX_SIZE * MAX_SIZE;
  localparam int unsigned AW    = (DEPTH > 1) ? $clog2(DEPTH) : 1;
  localparam int unsigned W_W   = FRAC_BITS + 1;   // raw weight UQ1.F
  localparam int unsigned SUM_W = FRAC_BITS + 6;   // sum of up to 49 weights
  localparam logic [2:0]  MAX_SZ = 3'(MAX_SIZE);
  localparam logic [NBIT_W-1:0] NORM_NBITS = NBIT_W'(2 * FRAC_BITS + 2);
  localparam logic [33:0] W_RND = 34'(1) << (31 - FRAC_BITS);

  typedef enum logic [3:0] {
    S_IDLE, S_ASTART, S_AWAIT, S_TMUL, S_TSTART, S_TWAIT, S_EMUL, S_EADD,
    S_STORE, S_RD, S_RDW, S_NSTART, S_NWAIT, S_PUT
  } state_e;

  state_e            state_q;
  logic [2:0]        sz_q, i_q, j_q, c_q;
  logic              mode_q;
  logic [23:0]       s2_q;
  logic [IDX_W-1:0]  idx_q, last_idx;
  logic [63:0]       a_q;
  logic [32:0]       term_q, sum_q;
  logic [3:0]        k_q;
  logic [4:0]        n_q, cnt_q;
  logic [64:0]       prod_q;
  logic [32:0]       mul_a;
  logic [31:0]       mul_b;
  logic [SUM_W-1:0]  total_q, divisor_q;
  logic [W_W-1:0]    tl_q, w_q, w_new;
  logic [W_W-1:0]    ram_rdata;
  logic [23:0]       coef_q;
  logic              out_vld_q;
  out_item_t         out_q;
  div_req_t          div_req;
  logic              div_done;
  logic [DVD_W-1:0]  div_quo;
  logic [2:0]        di, dj;
  logic [4:0]        d2;
  logic [2:0]        sz_in;
  logic [5:0]        sz_sq;
  logic [33:0]       w_sum;
  logic              take_out;

  // Distance of the current entry from the center
  assign di    = (i_q >= c_q) ? i_q - c_q : c_q - i_q;
  assign dj    = (j_q >= c_q) ? j_q - c_q : c_q - j_q;
  assign d2    = 5'(di * di) + 5'(dj * dj);
  assign sz_sq = 6'(sz_q * sz_q);
  assign last_idx = IDX_W'(sz_sq - 6'd1);
  assign sz_in = (in_item_i.kernel_size > MAX_SZ) ? MAX_SZ : in_item_i.kernel_size;

  // Raw weight rounded from Q32 to FRAC_BITS
  assign w_sum = {1'b0, sum_q} + W_RND;
  assign w_new = W_W'(w_sum >> (32 - FRAC_BITS));

  // Shared multiplier operand select
  always_comb begin
    mul_a = term_q;
    mul_b = a_q[31:0];
    if (state_q == S_EMUL) begin
      mul_a = sum_q;
      mul_b = INV_E_Q32;
    end
  end

  // Divider request by step
  always_comb begin
    div_req = '0;
    unique case (state_q)
      S_ASTART: begin
        div_req.start    = 1'b1;
        div_req.dividend = (DVD_W'(d2) << 47) + DVD_W'(s2_q >> 1);
        div_req.divisor  = DVS_W'(s2_q);
        div_req.nbits    = ARG_NBITS;
      end
      S_TSTART: begin
        div_req.start    = 1'b1;
        div_req.dividend = DVD_W'(prod_q[64:32]);
        div_req.divisor  = DVS_W'(k_q);
        div_req.nbits    = TERM_NBITS;
      end
      S_NSTART: begin
        div_req.start    = 1'b1;
        div_req.dividend = (DVD_W'(w_q) << FRAC_BITS) + DVD_W'(divisor_q >> 1);
        div_req.divisor  = DVS_W'(divisor_q);
        div_req.nbits    = NORM_NBITS;
      end
      default: ;
    endcase
  end

  gkg_div u_div (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .req_i      (div_req),
    .done_o     (div_done),
    .quotient_o (div_quo)
  );

  gkg_ram #(
    .WIDTH (W_W),
    .DEPTH (DEPTH)
  ) u_ram (
    .clk_i   (clk_i),
    .we_i    (state_q == S_STORE),
    .waddr_i (idx_q[AW-1:0]),
    .wdata_i (w_new),
    .raddr_i (idx_q[AW-1:0]),
    .rdata_o (ram_rdata)
  );

  assign take_out = !out_vld_q || !out_stall_i;

  // Sequencer and datapath registers
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q   <= S_IDLE;
      out_vld_q <= 1'b0;
      total_q   <= '0;
      idx_q     <= '0;
    end else begin
      // Emitted item leaves unless a new one is loaded in the same cycle
      if (out_vld_q && !out_stall_i && state_q != S_PUT) begin
        out_vld_q <= 1'b0;
      end
      unique case (state_q)
        S_IDLE: begin
          if (in_valid_i && in_item_i.kernel_size != 3'd0) begin
            sz_q    <= sz_in;
            c_q     <= sz_in >> 1;
            mode_q  <= in_item_i.mode;
            s2_q    <= (in_item_i.sigma == 12'd0) ? 24'd1 : in_item_i.sigma * in_item_i.sigma;
            i_q     <= '0;
            j_q     <= '0;
            idx_q   <= '0;
            total_q <= '0;
            state_q <= S_ASTART;
          end
        end
        S_ASTART: state_q <= S_AWAIT;
        S_AWAIT: begin
          if (div_done) begin
            a_q    <= div_quo;
            term_q <= 33'h1_0000_0000;
            k_q    <= 4'd1;
            n_q    <= div_quo[36:32];
            if (div_quo[63:32] > MAX_EXP_INT) begin
              sum_q   <= '0;
              state_q <= S_STORE;
            end else begin
              sum_q   <= 33'h1_0000_0000;
              state_q <= S_TMUL;
            end
          end
        end
        S_TMUL: begin
          prod_q  <= mul_a * mul_b;
          state_q <= S_TSTART;
        end
        S_TSTART: state_q <= S_TWAIT;
        S_TWAIT: begin
          if (div_done) begin
            term_q <= div_quo[32:0];
            if (k_q[0]) begin
              sum_q <= (sum_q >= div_quo[32:0]) ? sum_q - div_quo[32:0] : '0;
            end else begin
              sum_q <= sum_q + div_quo[32:0];
            end
            k_q <= k_q + 4'd1;
            cnt_q <= '0;
            if (k_q != SERIES_TERMS) begin
              state_q <= S_TMUL;
            end else if (n_q == 5'd0) begin
              state_q <= S_STORE;
            end else begin
              state_q <= S_EMUL;
            end
          end
        end
        S_EMUL: begin
          prod_q  <= mul_a * mul_b;
          state_q <= S_EADD;
        end
        S_EADD: begin
          sum_q <= 33'((prod_q + 65'h8000_0000) >> 32);
          cnt_q <= cnt_q + 5'd1;
          state_q <= (cnt_q + 5'd1 == n_q) ? S_STORE : S_EMUL;
        end
        S_STORE: begin
          total_q <= total_q + SUM_W'(w_new);
          if (idx_q == '0) begin
            tl_q <= w_new;
          end
          if (idx_q == last_idx) begin
            // Single-entry kernel: top-left weight is the one being stored
            divisor_q <= mode_q ? ((idx_q == '0) ? SUM_W'(w_new) : SUM_W'(tl_q))
                                : total_q + SUM_W'(w_new);
            i_q     <= '0;
            j_q     <= '0;
            idx_q   <= '0;
            state_q <= S_RD;
          end else begin
            idx_q <= idx_q + IDX_W'(1);
            if (j_q == sz_q - 3'd1) begin
              j_q <= '0;
              i_q <= i_q + 3'd1;
            end else begin
              j_q <= j_q + 3'd1;
            end
            state_q <= S_ASTART;
          end
        end
        S_RD: state_q <= S_RDW;
        S_RDW: begin
          w_q <= ram_rdata;
          if (divisor_q == '0) begin
            coef_q  <= COEF_MAX;
            state_q <= S_PUT;
          end else begin
            state_q <= S_NSTART;
          end
        end
        S_NSTART: state_q <= S_NWAIT;
        S_NWAIT: begin
          if (div_done) begin
            coef_q  <= (div_quo > DVD_W'(COEF_MAX)) ? COEF_MAX : div_quo[23:0];
            state_q <= S_PUT;
          end
        end
        S_PUT: begin
          if (take_out) begin
            out_vld_q           <= 1'b1;
            out_q.row           <= i_q;
            out_q.column        <= j_q;
            out_q.coefficient   <= coef_q;
            out_q.last          <= (idx_q == last_idx);
            if (idx_q == last_idx) begin
              state_q <= S_IDLE;
            end else begin
              idx_q <= idx_q + IDX_W'(1);
              if (j_q == sz_q - 3'd1) begin
                j_q <= '0;
                i_q <= i_q + 3'd1;
              end else begin
                j_q <= j_q + 3'd1;
              end
              state_q <= S_RD;
            end
          end
        end
        default: state_q <= S_IDLE;
      endcase
    end
  end

  assign in_stall_o  = (state_q != S_IDLE);
  assign out_valid_o = out_vld_q;
  assign out_item_o  = out_q;

endmodule

/* tb/sv/tb_top.sv */
// Testbench for the Gaussian kernel coefficient generator: directed and random requests.
module tb_top import gkg_pkg::*; ();

  localparam int unsigned KMAX      = 7;
  localparam int unsigned FRAC      = 16;
  localparam int unsigned WD_LIMIT  = 200000;
  localparam int unsigned N_RANDOM  = 300;
  localparam logic        MODE_SUM  = 1'b0;
  localparam logic        MODE_TL   = 1'b1;

  logic      clk_i;
  logic      rst_ni;
  logic      in_valid_i;
  logic      in_stall_o;
  in_item_t  in_item_i;
  logic      out_valid_o;
  logic      out_stall_i;
  out_item_t out_item_o;

  out_item_t coef_q[$];
  int        n_errors;
  int        idle_cycles;

  // Directed table: expected first coefficient given only where obvious
  typedef struct {
    in_item_t req;
    logic     has_first;
    logic [23:0] first_coef;
  } dir_row_t;

  gaussian_kernel_generator_unit #(.MAX_SIZE(KMAX), .FRAC_BITS(FRAC)) dut (
    .clk_i(clk_i), .rst_ni(rst_ni),
    .in_valid_i(in_valid_i), .in_stall_o(in_stall_o), .in_item_i(in_item_i),
    .out_valid_o(out_valid_o), .out_stall_i(out_stall_i), .out_item_o(out_item_o)
  );

  // Clock
  initial clk_i = 1'b0;
  always begin
    #4 clk_i = 1'b1;
    #4 clk_i = 1'b0;
  end

  // exp(-a), a and result in Q32
  function automatic logic [63:0] neg_exp_q32(input logic [63:0] a);
    logic [63:0]  n;
    logic [63:0]  r;
    logic [63:0]  acc;
    logic [63:0]  term;
    logic [127:0] prod;
    n    = a >> 32;
    r    = a & 64'hFFFF_FFFF;
    acc  = 64'd1 << 32;
    term = 64'd1 << 32;
    if (n > 64'd24) return 64'd0;
    for (int k = 1; k <= 12; k++) begin
      prod = term * r;
      term = 64'((prod >> 32) / k);
      if (k % 2 == 1) acc = (acc >= term) ? acc - term : 64'd0;
      else acc = acc + term;
    end
    for (int k = 0; k < n; k++) begin
      prod = acc * 64'd1580030169 + (128'd1 << 31);
      acc  = 64'(prod >> 32);
    end
    return acc;
  endfunction

  // Compute the kernel for one request and queue its coefficients
  task automatic queue_kernel(input in_item_t req);
    logic [63:0]  raw [KMAX*KMAX];
    logic [63:0]  sz, s, s2, c, di, dj, d2, a, e, total, divisor, q;
    logic [127:0] num;
    out_item_t    o;
    sz = 64'(req.kernel_size);
    if (sz == 0) return;
    if (sz > KMAX) sz = KMAX;
    s = 64'(req.sigma);
    if (s == 0) s = 1;
    s2 = s * s;
    c = sz / 2;
    total = 0;
    for (int i = 0; i < sz; i++)
      for (int j = 0; j < sz; j++) begin
        di = (i >= c) ? i - c : c - i;
        dj = (j >= c) ? j - c : c - j;
        d2 = di * di + dj * dj;
        num = ({64'd0, d2} << 47) + s2 / 2;
        a = 64'(num / s2);
        e = neg_exp_q32(a);
        raw[i*KMAX+j] = (e + (64'd1 << (31 - FRAC))) >> (32 - FRAC);
        total += raw[i*KMAX+j];
      end
    total = total & 64'hFFFF_FFFF;
    divisor = req.mode ? raw[0] : total;
    for (int k = 0; k < sz * sz; k++) begin
      o.row = 3'(k / sz);
      o.column = 3'(k % sz);
      if (divisor == 0) q = COEF_MAX;
      else begin
        q = ((raw[(k/sz)*KMAX + k%sz] << FRAC) + divisor / 2) / divisor;
        if (q > COEF_MAX) q = COEF_MAX;
      end
      o.coefficient = q[23:0];
      o.last = (k + 1 == sz * sz);
      coef_q.push_back(o);
    end
  endtask

  task automatic report(input string what);
    $display("tb_top: mismatch %s", what);
    n_errors++;
  endtask

  // Send one request, waiting a random gap first
  task automatic send_item(input in_item_t req);
    int gap;
    gap = (($urandom_range(0, 3) == 0) ? 0 : $urandom_range(0, 13));
    if (gap > 0) begin
      in_valid_i <= 1'b0;
      repeat (gap) @(posedge clk_i);
    end
    in_valid_i <= 1'b1;
    in_item_i  <= req;
    @(posedge clk_i);
    while (in_stall_o) @(posedge clk_i);
    queue_kernel(req);
  endtask

  // Output stall: each coefficient waits a drawn number of cycles
  initial begin
    int wait_n;
    out_stall_i = 1'b1;
    @(posedge rst_ni);
    forever begin
      wait_n = ($urandom_range(0, 2) == 0) ? 0 : $urandom_range(0, 13);
      if (wait_n > 0) begin
        out_stall_i <= 1'b1;
        repeat (wait_n) @(posedge clk_i);
      end
      out_stall_i <= 1'b0;
      @(posedge clk_i);
      while (!out_valid_o) @(posedge clk_i);
    end
  end

  // Result checker
  always @(posedge clk_i) begin
    out_item_t exp_o;
    if (rst_ni && out_valid_o && !out_stall_i) begin
      if (coef_q.size() == 0) report("coefficient with none expected");
      else begin
        exp_o = coef_q.pop_front();
        if (out_item_o.row != exp_o.row) report("row");
        if (out_item_o.column != exp_o.column) report("column");
        if (out_item_o.coefficient != exp_o.coefficient)
          report($sformatf("coefficient at (%0d,%0d): got %0h want %0h",
                           exp_o.row, exp_o.column, out_item_o.coefficient,
                           exp_o.coefficient));
        if (out_item_o.last != exp_o.last) report("last");
      end
    end
  end

  // Watchdog on cycles with no accepted item
  always @(posedge clk_i) begin
    if (!rst_ni || (in_valid_i && !in_stall_o) || (out_valid_o && !out_stall_i))
      idle_cycles <= 0;
    else idle_cycles <= idle_cycles + 1;
    if (idle_cycles >= WD_LIMIT) begin
      $display("tb_top: done, errors");
      $finish;
    end
  end

  // Stimulus
  initial begin
    dir_row_t  dir_tab[$];
    dir_row_t  row_d;
    in_item_t  req;
    out_item_t first_exp;
    int        sz_d;
    int        n_first;
    n_errors    = 0;
    in_valid_i  = 1'b0;
    in_item_i   = '0;
    rst_ni      = 1'b0;
    // size, sigma, mode, typed first coefficient
    dir_tab.push_back('{'{3'd1, 12'd256,  MODE_SUM}, 1'b1, 24'h010000});
    dir_tab.push_back('{'{3'd1, 12'd0,    MODE_TL},  1'b1, 24'h010000});
    dir_tab.push_back('{'{3'd0, 12'd256,  MODE_SUM}, 1'b0, 24'h0});
    dir_tab.push_back('{'{3'd7, 12'd4095, MODE_TL},  1'b1, 24'h010000});
    dir_tab.push_back('{'{3'd7, 12'd4095, MODE_SUM}, 1'b0, 24'h0});
    dir_tab.push_back('{'{3'd7, 12'd0,    MODE_TL},  1'b1, COEF_MAX});
    dir_tab.push_back('{'{3'd7, 12'd1,    MODE_SUM}, 1'b1, 24'h0});
    dir_tab.push_back('{'{3'd3, 12'd256,  MODE_SUM}, 1'b0, 24'h0});
    dir_tab.push_back('{'{3'd3, 12'd256,  MODE_TL},  1'b1, 24'h010000});
    dir_tab.push_back('{'{3'd5, 12'd2730, MODE_SUM}, 1'b0, 24'h0});
    dir_tab.push_back('{'{3'd2, 12'd64,   MODE_TL},  1'b1, COEF_MAX});
    dir_tab.push_back('{'{3'd4, 12'd1365, MODE_SUM}, 1'b0, 24'h0});
    dir_tab.push_back('{'{3'd6, 12'd16,   MODE_TL},  1'b0, 24'h0});
    dir_tab.push_back('{'{3'd0, 12'd4095, MODE_TL},  1'b0, 24'h0});
    repeat (6) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);
    foreach (dir_tab[k]) begin
      row_d = dir_tab[k];
      send_item(row_d.req);
      // This request's coefficients are the newest entries of the queue
      sz_d = int'(row_d.req.kernel_size);
      if (sz_d > KMAX) sz_d = KMAX;
      n_first = sz_d * sz_d;
      if (row_d.has_first && n_first > 0 && coef_q.size() >= n_first) begin
        first_exp = coef_q[coef_q.size() - n_first];
        if (first_exp.coefficient != row_d.first_coef)
          report($sformatf("typed row %0d disagrees with prediction", k));
      end
    end
    // Random: mostly small kernels, a few large ones
    for (int k = 0; k < N_RANDOM; k++) begin
      req.kernel_size = ($urandom_range(0, 9) == 0) ? 3'($urandom_range(0, 7))
                                                    : 3'($urandom_range(1, 3));
      req.sigma = ($urandom_range(0, 1) == 0) ? 12'($urandom_range(0, 4095))
                                              : 12'($urandom_range(0, 1023));
      req.mode  = 1'($urandom_range(0, 1));
      send_item(req);
    end
    in_valid_i <= 1'b0;
    while (coef_q.size() > 0) @(posedge clk_i);
    repeat (200) @(posedge clk_i);
    if (n_errors == 0) $display("tb_top: done, clean");
    else $display("tb_top: done, errors");
    $finish;
  end

endmodule

/* sim.f */
rtl/gkg_pkg.sv
rtl/gkg_ram.sv
rtl/gkg_div.sv
rtl/gaussian_kernel_generator_unit.sv
tb/sv/tb_top.sv
